// ===== rtl/core/chacha_stream_cipher_macros.svh =====
// Assertion macros shared by the cipher core modules.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef CHACHA_STREAM_CIPHER_MACROS_SVH
`define CHACHA_STREAM_CIPHER_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define CC_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition is followed in the next cycle by another.
`define CC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/cc_pkg.sv =====
// Shared types, constants and the block input builder for the ChaCha cipher.
// No dependencies.
package cc_pkg;

  localparam int unsigned DefRounds     = 20;
  localparam int unsigned DefCtrWords   = 2;
  localparam int unsigned DefQueueDepth = 2;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam logic [31:0] TAU1   = 32'h3120646e;
  localparam logic [31:0] TAU2   = 32'h79622d36;

  typedef enum logic [2:0] {
    REG_KEY01     = 3'd0,
    REG_KEY23     = 3'd1,
    REG_KEY45     = 3'd2,
    REG_KEY67     = 3'd3,
    REG_KEY_128   = 3'd4,
    REG_NONCE     = 3'd5,
    REG_START_BLK = 3'd6,
    REG_START_BYT = 3'd7
  } cc_reg_t;

  typedef logic [15:0][31:0] cc_words_t;

  typedef struct packed {
    logic [63:0] key01;
    logic [63:0] key23;
    logic [63:0] key45;
    logic [63:0] key67;
    logic        key_is_128;
    logic [63:0] nonce;
    logic [63:0] start_block;
    logic [5:0]  start_byte;
  } cc_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } cc_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cc_core_st_t;

  // Builds the sixteen-word block input from the key, counter and nonce.
  function automatic cc_words_t cc_build_init(cc_cfg_t cfg, logic [63:0] ctr,
                                              logic [63:0] upper);
    cc_words_t w;
    w[0]  = SIGMA0;
    w[1]  = cfg.key_is_128 ? TAU1 : SIGMA1;
    w[2]  = cfg.key_is_128 ? TAU2 : SIGMA2;
    w[3]  = SIGMA3;
    w[4]  = cfg.key01[31:0];
    w[5]  = cfg.key01[63:32];
    w[6]  = cfg.key23[31:0];
    w[7]  = cfg.key23[63:32];
    w[8]  = cfg.key_is_128 ? cfg.key01[31:0]  : cfg.key45[31:0];
    w[9]  = cfg.key_is_128 ? cfg.key01[63:32] : cfg.key45[63:32];
    w[10] = cfg.key_is_128 ? cfg.key23[31:0]  : cfg.key67[31:0];
    w[11] = cfg.key_is_128 ? cfg.key23[63:32] : cfg.key67[63:32];
    w[12] = ctr[31:0];
    w[13] = ctr[63:32];
    w[14] = upper[31:0];
    w[15] = upper[63:32];
    return w;
  endfunction

endpackage

// ===== rtl/core/cc_front.sv =====
// Front end: accepts input transactions into a short queue for the back end.
// Depends on cc_pkg.
module cc_front
  import cc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cc_item_t in_item,
  output logic     head_valid,
  output cc_item_t head_item,
  input  logic     pop
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cc_item_t            mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                push;

  assign in_ready   = (cnt_r != CntW'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== rtl/core/cc_core.sv =====
// Round engine: one add, xor and rotate step of four quarter rounds per cycle.
// Depends on cc_pkg.
module cc_core
  import cc_pkg::*;
#(
  parameter int unsigned ROUNDS = DefRounds
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  cc_words_t   init,
  output cc_core_st_t status,
  output cc_words_t   words
);

  localparam int unsigned NumRounds = ((ROUNDS + 1) / 2) * 2;
  localparam int unsigned RndW      = $clog2(NumRounds);

  cc_words_t       x_r, x_nxt;
  logic [1:0]      step_r;
  logic [RndW-1:0] round_r;
  logic            run_r;
  logic            done_r;

  assign status.busy = run_r;
  assign status.done = done_r;
  assign words       = x_r;

  always_comb begin
    logic [3:0] ia, ib, ic, id;
    logic [1:0] dg;
    x_nxt = x_r;
    dg    = {1'b0, round_r[0]};
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = {2'b01, 2'(q + dg)};
      ic = {2'b10, 2'(q + 2 * dg)};
      id = {2'b11, 2'(q + 3 * dg)};
      case (step_r)
        2'd0: begin
          x_nxt[ia] = x_r[ia] + x_r[ib];
          x_nxt[id] = x_r[id] ^ x_nxt[ia];
          x_nxt[id] = {x_nxt[id][15:0], x_nxt[id][31:16]};
        end
        2'd1: begin
          x_nxt[ic] = x_r[ic] + x_r[id];
          x_nxt[ib] = x_r[ib] ^ x_nxt[ic];
          x_nxt[ib] = {x_nxt[ib][19:0], x_nxt[ib][31:20]};
        end
        2'd2: begin
          x_nxt[ia] = x_r[ia] + x_r[ib];
          x_nxt[id] = x_r[id] ^ x_nxt[ia];
          x_nxt[id] = {x_nxt[id][23:0], x_nxt[id][31:24]};
        end
        default: begin
          x_nxt[ic] = x_r[ic] + x_r[id];
          x_nxt[ib] = x_r[ib] ^ x_nxt[ic];
          x_nxt[ib] = {x_nxt[ib][24:0], x_nxt[ib][31:25]};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      done_r  <= 1'b0;
      step_r  <= '0;
      round_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r   <= 1'b1;
        step_r  <= '0;
        round_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == 2'd3) begin
          if (round_r == RndW'(NumRounds - 1)) begin
            run_r  <= 1'b0;
            done_r <= 1'b1;
          end else begin
            round_r <= round_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= init;
    end else if (run_r) begin
      x_r <= x_nxt;
    end
  end

endmodule

// ===== rtl/core/cc_back.sv =====
// Back end: stream position, block counter, keystream buffer and result register.
// Depends on cc_pkg, cc_core and the assertion macro header.
`include "chacha_stream_cipher_macros.svh"

module cc_back
  import cc_pkg::*;
#(
  parameter int unsigned ROUNDS        = DefRounds,
  parameter int unsigned COUNTER_WORDS = DefCtrWords
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cc_cfg_t    cfg,
  input  logic       head_valid,
  input  cc_item_t   head_item,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_out
);

  localparam int unsigned CntBits = COUNTER_WORDS * 32;

  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_LAUNCH = 3'b010,
    ST_WAIT   = 3'b100
  } st_t;

  st_t          state_r;
  logic [63:0]  ctr_r;
  logic [63:0]  upper_r;
  logic [127:0] ctr_all, ctr_inc;
  logic [6:0]   pos_r;
  logic [5:0]   target_r;
  logic         rst_done_r;
  logic [511:0] ks_buf_r;
  logic         out_valid_r;
  logic [7:0]   out_data_r;
  logic         out_free;
  logic         need_restart;
  logic         load_out;
  logic         launch;
  logic [7:0]   ks_byte;
  cc_words_t    init_w;
  cc_words_t    core_words;
  cc_core_st_t  core_st;

  assign init_w       = cc_build_init(cfg, ctr_r, upper_r);
  assign out_free     = !out_valid_r || out_ready;
  assign need_restart = head_item.first && !rst_done_r;
  assign load_out     = (state_r == ST_RUN) && head_valid && !need_restart && !pos_r[6]
                        && out_free;
  assign pop          = load_out;
  assign launch       = (state_r == ST_LAUNCH);
  assign ks_byte      = ks_buf_r[{pos_r[5:0], 3'b000} +: 8];
  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;

  // The low COUNTER_WORDS words count as one little-endian number; no carry passes above them.
  always_comb begin
    ctr_all                 = {upper_r, ctr_r};
    ctr_inc                 = ctr_all;
    ctr_inc[CntBits-1:0]    = ctr_all[CntBits-1:0] + CntBits'(1);
  end

  cc_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (launch),
    .init   (init_w),
    .status (core_st),
    .words  (core_words)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      ctr_r       <= '0;
      upper_r     <= '0;
      pos_r       <= 7'd64;
      target_r    <= '0;
      rst_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (head_valid) begin
            if (need_restart) begin
              ctr_r      <= cfg.start_block;
              upper_r    <= cfg.nonce;
              rst_done_r <= 1'b1;
              if (cfg.start_byte != '0) begin
                target_r <= cfg.start_byte;
                state_r  <= ST_LAUNCH;
              end else begin
                pos_r <= 7'd64;
              end
            end else if (pos_r[6]) begin
              target_r <= '0;
              state_r  <= ST_LAUNCH;
            end else if (out_free) begin
              out_valid_r <= 1'b1;
              pos_r       <= pos_r + 1'b1;
              rst_done_r  <= 1'b0;
            end
          end
        end
        ST_LAUNCH: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (core_st.done) begin
            {upper_r, ctr_r} <= ctr_inc;
            pos_r            <= {1'b0, target_r};
            state_r          <= ST_RUN;
          end
        end
        default: begin
          state_r <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= head_item.data ^ ks_byte;
    end
    if ((state_r == ST_WAIT) && core_st.done) begin
      for (int i = 0; i < 16; i++) begin
        ks_buf_r[i*32 +: 32] <= core_words[i] + init_w[i];
      end
    end
  end

  `CC_CHECK(a_pop_only_in_run, !pop || (state_r == ST_RUN), "pop outside run state")
  `CC_CHECK(a_done_only_waiting, !core_st.done || (state_r == ST_WAIT), "core done unexpected")
  `CC_CHECK(a_load_buffer_full, !load_out || !pos_r[6], "byte taken from empty buffer")
  `CC_CHECK_NEXT(a_launch_starts_core, launch, core_st.busy, "core did not start")

endmodule

// ===== rtl/core/chacha_stream_cipher.sv =====
// ChaCha stream cipher, one byte per transaction: data_out = data_in XOR keystream.
// A byte passes through the front-end queue and the result register; throughput is one byte
// per cycle while the 64-byte keystream buffer holds bytes and the output is not stalled.
// Each new block is computed by the shared quarter-round step unit in cc_core.
// Reset (rst_n, synchronous, active low) clears configuration, counter and nonce
// and marks the keystream buffer empty; no clearing pass is needed.
module chacha_stream_cipher
  import cc_pkg::*;
#(
  parameter int unsigned ROUNDS        = DefRounds,
  parameter int unsigned COUNTER_WORDS = DefCtrWords,
  parameter int unsigned QUEUE_DEPTH   = DefQueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_in,
  input  logic        in_first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // The configuration registers are held here and handed to the back end as one
  // struct. Writes must arrive only while the block is idle, so that a keystream block
  // in generation always sees a stable key; the block itself does not enforce this.
  cc_cfg_t  cfg_r;
  cc_item_t in_item;
  cc_item_t head_item;
  logic     head_valid;
  logic     pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cc_reg_t'(cfg_index))
        REG_KEY01:     cfg_r.key01       <= cfg_wdata;
        REG_KEY23:     cfg_r.key23       <= cfg_wdata;
        REG_KEY45:     cfg_r.key45       <= cfg_wdata;
        REG_KEY67:     cfg_r.key67       <= cfg_wdata;
        REG_KEY_128:   cfg_r.key_is_128  <= cfg_wdata[0];
        REG_NONCE:     cfg_r.nonce       <= cfg_wdata;
        REG_START_BLK: cfg_r.start_block <= cfg_wdata;
        REG_START_BYT: cfg_r.start_byte  <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.data  = in_data_in;
  assign in_item.first = in_first;

  // The front end queues each accepted transaction so that the input side keeps
  // flowing while the back end waits on the result register or a new block.
  cc_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // The back end handles restarts, generates blocks on demand and keeps the
  // result register, which parts it from the output side.
  cc_back #(
    .ROUNDS        (ROUNDS),
    .COUNTER_WORDS (COUNTER_WORDS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out)
  );

endmodule

// ===== tb/sv/chacha_stream_cipher_checker.sv =====
// Scoreboard for the ChaCha byte cipher: it follows the register writes and the input
// transactions, works out each output byte and compares it with what the block sends.
// Depends on cc_pkg for the register codes and the sigma and tau constants.
module chacha_stream_cipher_checker
  import cc_pkg::*;
#(
  parameter int unsigned ROUNDS        = DefRounds,
  parameter int unsigned COUNTER_WORDS = DefCtrWords
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_in,
  input  logic        in_first,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_data_out,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  logic [63:0] key01, key23, key45, key67, nonce_reg, start_blk;
  logic        key_128;
  logic [5:0]  start_byt;
  logic [63:0] ctr_lo, ctr_hi;
  logic [31:0] ks_words [16];
  logic [31:0] mix [16];
  logic [6:0]  ks_pos;
  logic [7:0]  cipher_bytes [$];

  assign pending = cipher_bytes.size();

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic quarter(int a, int b, int c, int d);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
  endtask

  // Produces the next keystream block from the live key and then advances the counter.
  task automatic next_block();
    logic [31:0] seed [16];
    logic [31:0] c [4];
    seed[0] = SIGMA0;
    seed[1] = key_128 ? TAU1 : SIGMA1;
    seed[2] = key_128 ? TAU2 : SIGMA2;
    seed[3] = SIGMA3;
    seed[4] = key01[31:0]; seed[5] = key01[63:32];
    seed[6] = key23[31:0]; seed[7] = key23[63:32];
    seed[8]  = key_128 ? key01[31:0]  : key45[31:0];
    seed[9]  = key_128 ? key01[63:32] : key45[63:32];
    seed[10] = key_128 ? key23[31:0]  : key67[31:0];
    seed[11] = key_128 ? key23[63:32] : key67[63:32];
    seed[12] = ctr_lo[31:0]; seed[13] = ctr_lo[63:32];
    seed[14] = ctr_hi[31:0]; seed[15] = ctr_hi[63:32];
    mix = seed;
    for (int r = 0; r < ROUNDS; r += 2) begin
      quarter(0, 4, 8, 12); quarter(1, 5, 9, 13);
      quarter(2, 6, 10, 14); quarter(3, 7, 11, 15);
      quarter(0, 5, 10, 15); quarter(1, 6, 11, 12);
      quarter(2, 7, 8, 13); quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = mix[i] + seed[i];
    c[0] = ctr_lo[31:0]; c[1] = ctr_lo[63:32]; c[2] = ctr_hi[31:0]; c[3] = ctr_hi[63:32];
    for (int i = 0; i < COUNTER_WORDS && i < 4; i++) begin
      c[i] = c[i] + 32'd1;
      if (c[i] != 32'd0) break;
    end
    ctr_lo = {c[1], c[0]};
    ctr_hi = {c[3], c[2]};
  endtask

  task automatic encrypt_byte(logic [7:0] d, logic f);
    logic [31:0] w;
    if (f) begin
      ctr_lo = start_blk;
      ctr_hi = nonce_reg;
      ks_pos = 7'd64;
      if (start_byt != 6'd0) begin
        next_block();
        ks_pos = {1'b0, start_byt};
      end
    end
    if (ks_pos >= 7'd64) begin
      next_block();
      ks_pos = 7'd0;
    end
    w = ks_words[ks_pos[5:2]];
    cipher_bytes.push_back(d ^ 8'(w >> (ks_pos[1:0] * 8)));
    ks_pos = ks_pos + 7'd1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      {key01, key23, key45, key67, nonce_reg, start_blk} = '0;
      key_128 = 1'b0;
      start_byt = '0;
      ctr_lo = '0;
      ctr_hi = '0;
      ks_pos = 7'd64;
      cipher_bytes.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cc_reg_t'(cfg_index))
          REG_KEY01:     key01 = cfg_wdata;
          REG_KEY23:     key23 = cfg_wdata;
          REG_KEY45:     key45 = cfg_wdata;
          REG_KEY67:     key67 = cfg_wdata;
          REG_KEY_128:   key_128 = cfg_wdata[0];
          REG_NONCE:     nonce_reg = cfg_wdata;
          REG_START_BLK: start_blk = cfg_wdata;
          REG_START_BYT: start_byt = cfg_wdata[5:0];
          default: ;
        endcase
      end
      // Each accepted byte passes through the block's queue and result register, so an output
      // here never belongs to the input taken at this same edge.
      if (out_valid && out_ready) begin
        if (cipher_bytes.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output byte %02h", out_data_out);
        end else begin
          if (out_data_out !== cipher_bytes[0]) begin
            errors++;
            if (errors <= 10)
              $display("data_out mismatch: expected %02h, got %02h",
                       cipher_bytes[0], out_data_out);
          end
          void'(cipher_bytes.pop_front());
        end
      end
      if (in_valid && in_ready) encrypt_byte(in_data_in, in_first);
    end
  end

endmodule

// ===== tb/sv/chacha_stream_cipher_test.sv =====
// Top of the ChaCha byte cipher testbench: clock, reset, register writes, input stimulus,
// output back-pressure and the verdict. Depends on cc_pkg, the block and its checker.
module chacha_stream_cipher_test
  import cc_pkg::*;
;

  localparam int WatchdogLimit = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_in = '0;
  logic        in_first = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data_out;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  int errors, pending;
  int send_idle_pct = 0;   // chance in a hundred that the sender idles in a cycle
  int recv_idle_pct = 0;   // likewise for the receiver
  int hold_cycles = 0;     // a long back-pressure stretch requested by the stimulus
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  chacha_stream_cipher i_dut (.*);

  chacha_stream_cipher_checker i_checker (.*);

  // The receiver. A requested hold is counted down here, so that the sender carries on
  // offering bytes while the output is blocked and the block's queue fills up.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The watchdog counts cycles in which no transaction happens on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("chacha_stream_cipher_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte and returns just after the edge at which it is accepted. Valid is
  // left high so that back-to-back transactions need no second assignment in a step.
  // The write enable left high by the last register write is lowered here.
  task automatic send_byte(logic [7:0] d, logic f);
    cfg_we <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_in <= d;
    in_first <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  // Lowers valid and waits until every byte in flight has come back, so that the block
  // is idle before the registers are touched.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Writes one register. The enable stays high so that writes can follow back to back;
  // the next byte offered lowers it.
  task automatic write_reg(cc_reg_t idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // A 64-bit register value, biased towards the all-zero and all-one extremes.
  function automatic logic [63:0] pick64();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_setup();
    logic [5:0] sb;
    case ($urandom_range(3))
      0: sb = 6'd0;
      1: sb = 6'd63;
      default: sb = 6'($urandom_range(63));
    endcase
    write_reg(REG_KEY01, pick64());
    write_reg(REG_KEY23, pick64());
    write_reg(REG_KEY45, pick64());
    write_reg(REG_KEY67, pick64());
    write_reg(REG_KEY_128, 64'($urandom_range(1)));
    write_reg(REG_NONCE, pick64());
    write_reg(REG_START_BLK, pick64());
    write_reg(REG_START_BYT, 64'(sb));
  endtask

  // One phase: fresh settings, a restart, then a run of random bytes with the odd
  // restart mixed in so that start offsets meet partly used buffers.
  task automatic random_phase(int n);
    random_setup();
    send_byte(8'($urandom), 1'b1);
    for (int i = 1; i < n; i++) send_byte(8'($urandom), $urandom_range(24) == 0);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With no restart since reset the stream runs from counter zero and nonce zero.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b0);
    drain();

    // All-ones settings: the short key with tau, the last byte of a block as the start
    // offset, and a counter that wraps to zero once the first block is made.
    write_reg(REG_KEY01, '1);
    write_reg(REG_KEY23, '1);
    write_reg(REG_KEY45, '1);
    write_reg(REG_KEY67, '1);
    write_reg(REG_KEY_128, 64'd1);
    write_reg(REG_NONCE, '1);
    write_reg(REG_START_BLK, '1);
    write_reg(REG_START_BYT, 64'd63);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha5, 1'b0);
    drain();

    // All-zero settings with the full key; the restart with a zero offset leaves the
    // buffer empty, and a second restart throws away the rest of a block.
    write_reg(REG_KEY01, '0);
    write_reg(REG_KEY23, '0);
    write_reg(REG_KEY45, '0);
    write_reg(REG_KEY67, '0);
    write_reg(REG_KEY_128, 64'd0);
    write_reg(REG_NONCE, '0);
    write_reg(REG_START_BLK, '0);
    write_reg(REG_START_BYT, 64'd0);
    send_byte(8'h00, 1'b1);
    for (int i = 0; i < 6; i++) send_byte(8'(1 << i), 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7f, 1'b0);
    drain();

    // Random part in three idling regimes.
    send_idle_pct = 37;
    recv_idle_pct = 79;
    repeat (3) random_phase(45);
    send_idle_pct = 79;
    recv_idle_pct = 37;
    repeat (3) random_phase(45);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(45);

    // Long back-pressure while the sender keeps offering bytes, so the input stalls.
    random_setup();
    hold_cycles = 300;
    send_byte(8'($urandom), 1'b1);
    for (int i = 1; i < 60; i++) send_byte(8'($urandom), 1'b0);
    drain();
    random_phase(45);

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("chacha_stream_cipher_test: done, clean");
    end else begin
      $display("chacha_stream_cipher_test: done, errors");
    end
    $finish;
  end

endmodule
